// ===== sv/triangle_bbox_accumulator_macros.svh =====
// Assertion helpers for the bounding box accumulator.
`ifndef TRIANGLE_BBOX_ACCUMULATOR_MACROS_SVH
`define TRIANGLE_BBOX_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tba_pkg.sv =====
`timescale 1ns / 1ps

package tba_pkg;

  typedef logic signed [31:0] q_t;

  localparam q_t QMAX = 32'sh7FFF_FFFF;
  localparam q_t QMIN = 32'sh8000_0000;

  localparam int unsigned SLACK_W  = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned AREA_W   = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_SLACK_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLACK_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLACK_Z = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic start_req;
    q_t   v0_x;
    q_t   v0_y;
    q_t   v0_z;
    q_t   v1_x;
    q_t   v1_y;
    q_t   v1_z;
    q_t   v2_x;
    q_t   v2_y;
    q_t   v2_z;
  } in_t;

  typedef struct packed {
    q_t                out_lo_x;
    q_t                out_lo_y;
    q_t                out_lo_z;
    q_t                out_hi_x;
    q_t                out_hi_y;
    q_t                out_hi_z;
    logic [1:0]        largest_axis;
    q_t                center_x;
    q_t                center_y;
    q_t                center_z;
    logic [AREA_W-1:0] surface_area;
  } out_t;

  // Per-axis box, index 0 x, 1 y, 2 z.
  typedef struct packed {
    q_t [2:0] lo;
    q_t [2:0] hi;
  } box_t;

endpackage

// ===== sv/tba_stream_if.sv =====
`timescale 1ns / 1ps

interface tba_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/triangle_bbox_accumulator.sv =====
`timescale 1ns / 1ps
// Triangle bounding box accumulator, signed Q16.16.
// in_i  : valid/ready word with start_req and three points. start_req = 1
//         restarts the running box from the points, 0 merges them in.
// out_o : valid/ready word with the box widened by the per-axis slack
//         (saturating), the largest axis, the center and the surface area.
// cfg   : cfg_we_i writes slack register cfg_idx_i (0 x, 1 y, 2 z) with
//         cfg_wdata_i; other indexes are ignored. Write only while idle.
// Pipe: box update, slack saturation, extents, products, area sum, each
//   registered; the box update registers at the edge that accepts the word.
// Throughput: one word per cycle while in_i.ready is high. The running box
//   is updated in the cycle of acceptance, so merges chain back to back;
//   the rest is a 4-stage pipe.
// Stall: each stage loads whenever it is empty or the stage after it moves,
//   so bubbles fill while out_o is held. in_i.ready drops only once all
//   five stages hold words.
// Reset: pipe emptied, slack cleared, box set empty (lo most positive,
//   hi most negative), so a merge with no prior start reports its own points' box.

`include "triangle_bbox_accumulator_macros.svh"

module triangle_bbox_accumulator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tba_stream_if.sink                       in_i,
  tba_stream_if.source                     out_o,
  input  logic                             cfg_we_i,
  input  logic [tba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tba_pkg::SLACK_W-1:0]      cfg_wdata_i
);

  // ---------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------
  function automatic tba_pkg::q_t min3(tba_pkg::q_t a, tba_pkg::q_t b, tba_pkg::q_t c);
    tba_pkg::q_t m;
    m = ($signed(a) < $signed(b)) ? a : b;
    return ($signed(m) < $signed(c)) ? m : c;
  endfunction

  function automatic tba_pkg::q_t max3(tba_pkg::q_t a, tba_pkg::q_t b, tba_pkg::q_t c);
    tba_pkg::q_t m;
    m = ($signed(a) > $signed(b)) ? a : b;
    return ($signed(m) > $signed(c)) ? m : c;
  endfunction

  // Clamp a 33-bit signed value into 32 bits.
  function automatic tba_pkg::q_t sat33(logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? tba_pkg::QMIN : tba_pkg::QMAX;
    end
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------
  logic [2:0][tba_pkg::SLACK_W-1:0] slack_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slack_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tba_pkg::CFG_SLACK_X: slack_q[0] <= cfg_wdata_i;
        tba_pkg::CFG_SLACK_Y: slack_q[1] <= cfg_wdata_i;
        tba_pkg::CFG_SLACK_Z: slack_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipe control: stage k moves when empty or when stage k+1 moves
  // ---------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic adv1, adv2, adv3, adv4, adv5;
  logic in_acc;

  assign adv5 = !s5_v_q || out_o.ready;
  assign adv4 = !s4_v_q || adv5;
  assign adv3 = !s3_v_q || adv4;
  assign adv2 = !s2_v_q || adv3;
  assign adv1 = !s1_v_q || adv2;

  assign in_i.ready = adv1;
  assign in_acc     = in_i.valid && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= in_i.valid;
      if (adv2) s2_v_q <= s1_v_q;
      if (adv3) s3_v_q <= s2_v_q;
      if (adv4) s4_v_q <= s3_v_q;
      if (adv5) s5_v_q <= s4_v_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: running box update on acceptance
  // ---------------------------------------------------------------
  tba_pkg::box_t box_q, box_d, s1_q;
  tba_pkg::q_t [2:0] pt0, pt1, pt2;

  assign pt0 = {in_i.data.v0_z, in_i.data.v0_y, in_i.data.v0_x};
  assign pt1 = {in_i.data.v1_z, in_i.data.v1_y, in_i.data.v1_x};
  assign pt2 = {in_i.data.v2_z, in_i.data.v2_y, in_i.data.v2_x};

  always_comb begin
    tba_pkg::q_t nl, nh;
    box_d = box_q;
    for (int a = 0; a < 3; a++) begin
      nl = min3(pt0[a], pt1[a], pt2[a]);
      nh = max3(pt0[a], pt1[a], pt2[a]);
      if (in_i.data.start_req) begin
        box_d.lo[a] = nl;
        box_d.hi[a] = nh;
      end else begin
        box_d.lo[a] = ($signed(nl) < $signed(box_q.lo[a])) ? nl : box_q.lo[a];
        box_d.hi[a] = ($signed(nh) > $signed(box_q.hi[a])) ? nh : box_q.hi[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q.lo <= {3{tba_pkg::QMAX}};
      box_q.hi <= {3{tba_pkg::QMIN}};
    end else if (in_acc) begin
      box_q <= box_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= box_d;
  end

  // ---------------------------------------------------------------
  // Stage 2: widen by slack, saturating
  // ---------------------------------------------------------------
  tba_pkg::box_t s2_d, s2_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s2_d.lo[a] = sat33($signed({s1_q.lo[a][31], s1_q.lo[a]}) -
                         $signed({2'b00, slack_q[a]}));
      s2_d.hi[a] = sat33($signed({s1_q.hi[a][31], s1_q.hi[a]}) +
                         $signed({2'b00, slack_q[a]}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_v_q) s2_q <= s2_d;
  end

  // ---------------------------------------------------------------
  // Stage 3: extents, largest axis, center
  // ---------------------------------------------------------------
  logic signed [2:0][32:0] dext;
  logic [2:0][31:0]        ext_d, ext_q;
  tba_pkg::q_t [2:0]       ctr_d, ctr_q;
  logic [1:0]              axis_d, axis_q;
  tba_pkg::box_t           s3_q;

  always_comb begin
    logic signed [32:0] hsum;
    for (int a = 0; a < 3; a++) begin
      dext[a]  = $signed({s2_q.hi[a][31], s2_q.hi[a]}) - $signed({s2_q.lo[a][31], s2_q.lo[a]});
      ext_d[a] = ($signed(dext[a]) > 33'sd0) ? dext[a][31:0] : 32'd0;
      hsum     = $signed({s2_q.hi[a][31], s2_q.hi[a]}) + $signed({s2_q.lo[a][31], s2_q.lo[a]});
      ctr_d[a] = hsum[32:1];  // floor of half
    end
    // x needs to beat both strictly; y needs to beat z strictly
    if ($signed(dext[0]) > $signed(dext[1]) && $signed(dext[0]) > $signed(dext[2])) begin
      axis_d = tba_pkg::AXIS_X;
    end else if ($signed(dext[1]) > $signed(dext[2])) begin
      axis_d = tba_pkg::AXIS_Y;
    end else begin
      axis_d = tba_pkg::AXIS_Z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_v_q) begin
      s3_q   <= s2_q;
      ext_q  <= ext_d;
      ctr_q  <= ctr_d;
      axis_q <= axis_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: face products, one 32x32 multiplier each
  // ---------------------------------------------------------------
  logic [2:0][63:0]  prod_q;
  tba_pkg::box_t     s4_q;
  tba_pkg::q_t [2:0] ctr4_q;
  logic [1:0]        axis4_q;

  always_ff @(posedge clk_i) begin
    if (adv4 && s3_v_q) begin
      prod_q[0] <= ext_q[0] * ext_q[1];
      prod_q[1] <= ext_q[0] * ext_q[2];
      prod_q[2] <= ext_q[1] * ext_q[2];
      s4_q      <= s3_q;
      ctr4_q    <= ctr_q;
      axis4_q   <= axis_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: area sum and output register
  // ---------------------------------------------------------------
  logic [65:0]  psum;
  tba_pkg::out_t out_d, out_q;

  assign psum = {2'b00, prod_q[0]} + {2'b00, prod_q[1]} + {2'b00, prod_q[2]};

  always_comb begin
    out_d.out_lo_x     = s4_q.lo[0];
    out_d.out_lo_y     = s4_q.lo[1];
    out_d.out_lo_z     = s4_q.lo[2];
    out_d.out_hi_x     = s4_q.hi[0];
    out_d.out_hi_y     = s4_q.hi[1];
    out_d.out_hi_z     = s4_q.hi[2];
    out_d.largest_axis = axis4_q;
    out_d.center_x     = ctr4_q[0];
    out_d.center_y     = ctr4_q[1];
    out_d.center_z     = ctr4_q[2];
    // 2 * sum / 2^16; the sum stays below 2^66, so 51 bits survive
    out_d.surface_area = {{(tba_pkg::AREA_W - 51){1'b0}}, psum[65:15]};
  end

  always_ff @(posedge clk_i) begin
    if (adv5 && s4_v_q) out_q <= out_d;
  end

  assign out_o.valid = s5_v_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `TBA_ASSERT_NEXT(a_start_box_ordered, clk_i, rst_ni, in_acc && in_i.data.start_req,
    $signed(box_q.lo[0]) <= $signed(box_q.hi[0]) &&
    $signed(box_q.lo[1]) <= $signed(box_q.hi[1]) &&
    $signed(box_q.lo[2]) <= $signed(box_q.hi[2]),
    "box not ordered after start")
  `TBA_ASSERT_NEXT(a_merge_never_shrinks, clk_i, rst_ni, in_acc && !in_i.data.start_req,
    $signed(box_q.lo[0]) <= $signed($past(box_q.lo[0])) &&
    $signed(box_q.hi[0]) >= $signed($past(box_q.hi[0])),
    "merge shrank the box on x")
  `TBA_ASSERT_NOW(a_area_bound, clk_i, rst_ni, out_o.valid,
    out_o.data.surface_area[tba_pkg::AREA_W-1:51] == '0, "surface area out of range")
  `TBA_ASSERT_NOW(a_axis_code, clk_i, rst_ni, out_o.valid,
    out_o.data.largest_axis != 2'd3, "bad largest axis code")
  `TBA_ASSERT_NEXT(a_box_holds_idle, clk_i, rst_ni, !in_acc,
    box_q == $past(box_q), "box changed without an accepted word")

endmodule

// ===== verif/tba_box_monitor.sv =====
`timescale 1ns / 1ps

module tba_box_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  tba_pkg::in_t                  in_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  tba_pkg::out_t                 out_word_i,
  input  logic                          cfg_we_i,
  input  logic [tba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tba_pkg::SLACK_W-1:0]   cfg_wdata_i,
  output int                            mismatches_o,
  output int                            outstanding_o,
  output int                            compared_o
);
  import tba_pkg::*;

  localparam int REPORT_LIMIT = 30;

  // running box and slack, index 0 x, 1 y, 2 z
  q_t                 run_lo [3];
  q_t                 run_hi [3];
  logic [SLACK_W-1:0] margin [3];
  out_t               expected_boxes [$];

  function automatic q_t clip_q(longint v);
    if (v > longint'(QMAX)) return QMAX;
    if (v < longint'(QMIN)) return QMIN;
    return v[31:0];
  endfunction

  // Folds one word into the running box, returns the widened report.
  function automatic out_t fold_points(in_t w);
    q_t          pts [3][3];
    q_t          lo_n;
    q_t          hi_n;
    q_t          lo_w [3];
    q_t          hi_w [3];
    q_t          mid [3];
    longint      span [3];
    longint      sum_lh;
    logic [65:0] ext [3];
    logic [65:0] faces;
    out_t        r;
    pts[0] = '{w.v0_x, w.v0_y, w.v0_z};
    pts[1] = '{w.v1_x, w.v1_y, w.v1_z};
    pts[2] = '{w.v2_x, w.v2_y, w.v2_z};
    for (int a = 0; a < 3; a++) begin
      lo_n = pts[0][a];
      hi_n = pts[0][a];
      for (int v = 1; v < 3; v++) begin
        if (pts[v][a] < lo_n) lo_n = pts[v][a];
        if (pts[v][a] > hi_n) hi_n = pts[v][a];
      end
      if (w.start_req) begin
        run_lo[a] = lo_n;
        run_hi[a] = hi_n;
      end else begin
        if (lo_n < run_lo[a]) run_lo[a] = lo_n;
        if (hi_n > run_hi[a]) run_hi[a] = hi_n;
      end
      lo_w[a] = clip_q(longint'(run_lo[a]) - longint'(margin[a]));
      hi_w[a] = clip_q(longint'(run_hi[a]) + longint'(margin[a]));
      span[a] = longint'(hi_w[a]) - longint'(lo_w[a]);
      ext[a]  = (span[a] > 0) ? 66'(span[a]) : '0;
      sum_lh  = longint'(hi_w[a]) + longint'(lo_w[a]);
      mid[a]  = sum_lh[32:1];  // floor of half
    end
    if (span[0] > span[1] && span[0] > span[2]) r.largest_axis = AXIS_X;
    else if (span[1] > span[2])                 r.largest_axis = AXIS_Y;
    else                                        r.largest_axis = AXIS_Z;
    faces = ext[0] * ext[1] + ext[0] * ext[2] + ext[1] * ext[2];
    r.surface_area = 63'(faces >> 15);  // times two, drop 16 fraction bits
    r.out_lo_x = lo_w[0];
    r.out_lo_y = lo_w[1];
    r.out_lo_z = lo_w[2];
    r.out_hi_x = hi_w[0];
    r.out_hi_y = hi_w[1];
    r.out_hi_z = hi_w[2];
    r.center_x = mid[0];
    r.center_y = mid[1];
    r.center_z = mid[2];
    return r;
  endfunction

  task automatic check_field(string tag, logic [62:0] want, logic [62:0] got);
    if (want !== got) begin
      mismatches_o++;
      if (mismatches_o <= REPORT_LIMIT)
        $display("%0t: %s expected %0h actual %0h", $time, tag, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        run_lo[a] = QMAX;
        run_hi[a] = QMIN;
        margin[a] = '0;
      end
      expected_boxes.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_boxes.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= REPORT_LIMIT)
            $display("%0t: unexpected word, expected none actual %h", $time, out_word_i);
        end else begin
          want = expected_boxes.pop_front();
          compared_o++;
          check_field("out_lo_x", 63'(want.out_lo_x), 63'(out_word_i.out_lo_x));
          check_field("out_lo_y", 63'(want.out_lo_y), 63'(out_word_i.out_lo_y));
          check_field("out_lo_z", 63'(want.out_lo_z), 63'(out_word_i.out_lo_z));
          check_field("out_hi_x", 63'(want.out_hi_x), 63'(out_word_i.out_hi_x));
          check_field("out_hi_y", 63'(want.out_hi_y), 63'(out_word_i.out_hi_y));
          check_field("out_hi_z", 63'(want.out_hi_z), 63'(out_word_i.out_hi_z));
          check_field("largest_axis", 63'(want.largest_axis),
                      63'(out_word_i.largest_axis));
          check_field("center_x", 63'(want.center_x), 63'(out_word_i.center_x));
          check_field("center_y", 63'(want.center_y), 63'(out_word_i.center_y));
          check_field("center_z", 63'(want.center_z), 63'(out_word_i.center_z));
          check_field("surface_area", want.surface_area, out_word_i.surface_area);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLACK_X: margin[0] = cfg_wdata_i;
          CFG_SLACK_Y: margin[1] = cfg_wdata_i;
          CFG_SLACK_Z: margin[2] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_boxes.push_back(fold_points(in_word_i));
    end
    outstanding_o = expected_boxes.size();
  end

endmodule

// ===== verif/tb_triangle_bbox_accumulator.sv =====
`timescale 1ns / 1ps

module tb_triangle_bbox_accumulator;
  import tba_pkg::*;

  // Slowest legal run is ~1200 words, each with a long gap and a long stall plus the pipe.
  localparam int MAX_CYCLES = 1_000_000;
  // Pipe depth is 5; give a little extra before touching the slack registers.
  localparam int SETTLE_CYCLES = 6;
  // Index past the last slack register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [SLACK_W-1:0]   SLACK_MAX  = '1;

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SLACK_W-1:0]   cfg_wdata;

  tba_stream_if #(.T(in_t))  pts_ch ();
  tba_stream_if #(.T(out_t)) box_ch ();

  int  mismatches;
  int  outstanding;
  int  compared;
  int  words_sent;
  int  settings;
  int  cycles;
  bit  quiet;       // no gaps and no stalls while set
  bit  pts_taken;   // word accepted at the last rising edge

  always #5 clk = ~clk;

  triangle_bbox_accumulator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (pts_ch),
    .out_o       (box_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tba_box_monitor box_monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (pts_ch.valid),
    .in_ready_i    (pts_ch.ready),
    .in_word_i     (pts_ch.data),
    .out_valid_i   (box_ch.valid),
    .out_ready_i   (box_ch.ready),
    .out_word_i    (box_ch.data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  // Handshake sampled at the rising edge, read by the driver at the falling one.
  always @(posedge clk) pts_taken <= pts_ch.valid && pts_ch.ready;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side backpressure: mostly ready, short stalls, now and then a long
  // one that fills the pipe and pushes back on the input.
  int unsigned ready_hold;
  always @(negedge clk) begin
    if (quiet) begin
      box_ch.ready = 1'b1;
      ready_hold   = 0;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 2) != 0) begin
      box_ch.ready = 1'b1;
      ready_hold   = $urandom_range(0, 11);
    end else begin
      box_ch.ready = 1'b0;
      ready_hold   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
    end
  end

  // Sender gap: mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned gap_cycles();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t pack_points(logic s, q_t ax, ay, az, bx, by, bz, cx, cy, cz);
    in_t w;
    w.start_req = s;
    w.v0_x = ax; w.v0_y = ay; w.v0_z = az;
    w.v1_x = bx; w.v1_y = by; w.v1_z = bz;
    w.v2_x = cx; w.v2_y = cy; w.v2_z = cz;
    return w;
  endfunction

  // Coordinate near a cluster center; occasional extremes and wild values so
  // every bit toggles and saturation paths get hit.
  function automatic q_t near(q_t c, int unsigned spread);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      case ($urandom_range(0, 4))
        0:       return QMIN;
        1:       return QMAX;
        2:       return 0;
        3:       return -1;
        default: return 1;
      endcase
    end
    if (r < 25) return q_t'($urandom);
    return c + (q_t'($urandom) >>> (32 - spread));
  endfunction

  function automatic in_t scatter(logic s, q_t cx, cy, cz, int unsigned spread);
    return pack_points(s, near(cx, spread), near(cy, spread), near(cz, spread),
                          near(cx, spread), near(cy, spread), near(cz, spread),
                          near(cx, spread), near(cy, spread), near(cz, spread));
  endfunction

  task automatic send_points(in_t w);
    int unsigned gap;
    gap = gap_cycles();
    if (gap != 0) begin
      pts_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pts_ch.valid = 1'b1;
    pts_ch.data  = w;
    do @(negedge clk); while (!pts_taken);
    words_sent++;
  endtask

  // Hold off the sender until every predicted box has come back.
  task automatic wait_idle();
    pts_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_slack(logic [CFG_IDX_W-1:0] idx, logic [SLACK_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_slack(logic [SLACK_W-1:0] sx, sy, sz);
    wait_idle();
    write_slack(CFG_SLACK_X, sx);
    write_slack(CFG_SLACK_Y, sy);
    write_slack(CFG_SLACK_Z, sz);
    settings++;
  endtask

  // Mostly well-formed builds: a start word then a run of merges around one
  // cluster, some merged as child boxes (lo, hi, hi). The rest is noise and
  // merge runs with no start of their own.
  task automatic random_run(int n);
    int          target;
    int unsigned kind;
    int unsigned len;
    int unsigned spread;
    q_t          cx, cy, cz, lx, ly, lz, hx, hy, hz;
    target = words_sent + n;
    while (words_sent < target) begin
      kind   = $urandom_range(0, 9);
      spread = $urandom_range(4, 31);
      cx     = q_t'($urandom);
      cy     = q_t'($urandom);
      cz     = q_t'($urandom);
      if (kind == 0) begin
        send_points(scatter(1'($urandom_range(0, 1)), cx, cy, cz, 31));
      end else if (kind == 1) begin
        len = $urandom_range(1, 4);
        repeat (len) send_points(scatter(1'b0, cx, cy, cz, spread));
      end else begin
        send_points(scatter(1'b1, cx, cy, cz, spread));
        len = $urandom_range(1, 12);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            lx = near(cx, spread);
            ly = near(cy, spread);
            lz = near(cz, spread);
            hx = lx + q_t'($urandom >> (32 - spread));
            hy = ly + q_t'($urandom >> (32 - spread));
            hz = lz + q_t'($urandom >> (32 - spread));
            send_points(pack_points(1'b0, lx, ly, lz, hx, hy, hz, hx, hy, hz));
          end else begin
            send_points(scatter(1'b0, cx, cy, cz, spread));
          end
        end
      end
    end
  endtask

  initial begin
    quiet        = 1'b0;
    pts_ch.valid = 1'b0;
    pts_ch.data  = '0;
    box_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_SLACK_X;
    cfg_wdata    = '0;
    settings     = 1;  // reset value, all slack zero

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed, zero slack.
    // merge straight after reset, no start: folds into the empty box
    send_points(pack_points(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // full range on every axis: largest extents, area near its top, tie -> z
    send_points(pack_points(1'b1, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, 0, 0, 0));
    // degenerate box, zero extents
    send_points(pack_points(1'b1, 5, 5, 5, 5, 5, 5, 5, 5, 5));
    // x ties y above z: y wins
    send_points(pack_points(1'b1, 0, 0, 0, 10, 10, 4, 3, 3, 3));
    // y ties z above x: z wins
    send_points(pack_points(1'b1, 0, 0, 0, 3, 7, 7, 1, 1, 1));
    // x strictly largest
    send_points(pack_points(1'b1, 0, 0, 0, 9, 2, 2, 1, 1, 1));
    // child box merged as lo, hi, hi
    send_points(pack_points(1'b0, -20, -20, -20, 30, 30, 30, 30, 30, 30));
    // points inside the box leave it alone
    send_points(pack_points(1'b0, 1, 2, 3, 4, 5, 6, 0, 0, 0));
    // negative odd sums on y and z: center rounds toward minus infinity
    send_points(pack_points(1'b1, -3, -5, -7, -2, -2, -2, -4, -4, -4));
    // merge stretching single axes to the rails
    send_points(pack_points(1'b0, QMIN, 0, 0, 0, QMAX, 0, 0, 0, 0));
    send_points(pack_points(1'b1, QMAX, QMIN, -1, QMAX, QMIN, -1, QMAX, QMIN, -1));

    random_run(250);

    // Full-scale slack: ends near the rails saturate. The unused index must be ignored.
    set_slack(SLACK_MAX, SLACK_MAX, SLACK_MAX);
    write_slack(CFG_UNUSED, SLACK_W'($urandom));
    send_points(pack_points(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_points(pack_points(1'b1, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, 0, 0, 0));
    send_points(pack_points(1'b1, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
    send_points(pack_points(1'b0, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN));
    random_run(150);

    // Small slack; first part runs with no gaps and no stalls at all.
    set_slack(SLACK_W'($urandom_range(0, 1 << 20)), SLACK_W'($urandom_range(0, 1 << 20)),
              SLACK_W'($urandom_range(0, 1 << 20)));
    quiet = 1'b1;
    random_run(100);
    quiet = 1'b0;
    random_run(150);

    // Mixed: full 31-bit random on two axes, zero on the third.
    set_slack(SLACK_W'($urandom), '0, SLACK_W'($urandom));
    random_run(120);
    wait_idle();  // sender holds until the pipe has fully drained
    random_run(130);
    set_slack('0, SLACK_MAX, SLACK_W'($urandom));
    write_slack(CFG_UNUSED, SLACK_W'($urandom));
    random_run(120);

    // Back to zero slack to close.
    set_slack('0, '0, '0);
    random_run(130);

    wait_idle();
    $display("Sent %0d point words over %0d slack settings (zero, full-scale, small, mixed).",
             words_sent, settings);
    $display("Compared %0d boxes, %0d field mismatches.", compared, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
